// File: sv/dq_pkg.sv
// dq_pkg: operation codes, status codes and the control state type of
// the deque core. No dependencies.
`default_nettype none

package dq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4,
    OP_REPLACE    = 3'd5
  } op_t;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_NOTFOUND = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_POP  = 4'b0100,
    S_SCAN = 4'b1000
  } state_t;

endpackage : dq_pkg

`default_nettype wire

// File: sv/double_ended_queue_with_replace_core.sv
// double_ended_queue_with_replace_core: bounded deque of signed 32-bit values
// held in a ring memory, with dump and replace-first-match.
// Depends on dq_pkg.
//
//   channel   ports                                   handshake
//   input     in_op, in_value, in_new_value           start & !busy
//   result    out_status, out_data, out_last          out_strobe, one cycle
//
// Push and unused codes: accept, then execute; the result is registered out of execute.
// Pop: a pop state follows execute for the registered memory read.
// Dump and replace: one read per cycle over the stored entries, after
// execute; dump gives one result per element, the last marked.
// busy stays high until the item's last result; the receiver cannot stall.
// Reset gives an empty queue with front at zero; no clearing pass is needed.
`default_nettype none

module double_ended_queue_with_replace_core #(
  parameter int DEPTH = 32
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  output logic                     busy,
  input  wire  [2:0]               in_op,
  input  wire  signed [31:0]       in_value,
  input  wire  signed [31:0]       in_new_value,
  output logic                     out_strobe,
  output dq_pkg::status_t          out_status,
  output logic signed [31:0]       out_data,
  output logic                     out_last
);
  import dq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef logic [IW-1:0] idx_t;
  typedef logic [CW-1:0] cnt_t;

  // ring storage
  logic [31:0] mem_r [DEPTH];
  logic [31:0] rd_data_r;
  idx_t        rd_addr;
  logic        we;
  idx_t        wa;
  logic [31:0] wd;

  state_t      state_r, state_nxt;
  op_t         op_r;
  logic [31:0] value_r, new_value_r;
  idx_t        front_r, front_nxt;
  cnt_t        count_r, count_nxt;
  idx_t        ptr_r, ptr_nxt;
  idx_t        daddr_r, daddr_nxt;
  idx_t        idx_r, idx_nxt;

  logic        strobe_nxt;
  status_t     status_nxt;
  logic [31:0] data_nxt;
  logic        last_nxt;

  logic        is_full, is_empty, is_last;

  function automatic idx_t wrap(input logic [IW:0] s);
    logic [IW:0] r;
    r = (s >= (IW+1)'(DEPTH)) ? s - (IW+1)'(DEPTH) : s;
    return r[IW-1:0];
  endfunction

  function automatic idx_t inc(input idx_t p);
    return (p == IW'(DEPTH - 1)) ? '0 : p + IW'(1);
  endfunction

  function automatic idx_t dec(input idx_t p);
    return (p == '0) ? IW'(DEPTH - 1) : p - IW'(1);
  endfunction

  assign busy     = (state_r != S_IDLE);
  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);
  assign is_last  = (CW'(idx_r) + CW'(1) == count_r);

  always_comb begin
    state_nxt  = state_r;
    front_nxt  = front_r;
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    daddr_nxt  = daddr_r;
    idx_nxt    = idx_r;
    rd_addr    = ptr_r;
    we         = 1'b0;
    wa         = front_r;
    wd         = value_r;
    strobe_nxt = 1'b0;
    status_nxt = ST_OK;
    data_nxt   = '0;
    last_nxt   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt  = S_IDLE;
        strobe_nxt = 1'b1;
        last_nxt   = 1'b1;
        case (op_r)
          OP_PUSH_FRONT: begin
            if (is_full) begin
              status_nxt = ST_FULL;
            end else begin
              we        = 1'b1;
              wa        = dec(front_r);
              front_nxt = dec(front_r);
              count_nxt = count_r + CW'(1);
            end
          end
          OP_PUSH_BACK: begin
            if (is_full) begin
              status_nxt = ST_FULL;
            end else begin
              we        = 1'b1;
              wa        = wrap((IW+1)'(front_r) + (IW+1)'(count_r));
              count_nxt = count_r + CW'(1);
            end
          end
          OP_POP_FRONT: begin
            if (is_empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              rd_addr    = front_r;
              strobe_nxt = 1'b0;
              state_nxt  = S_POP;
            end
          end
          OP_POP_BACK: begin
            if (is_empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              rd_addr    = wrap((IW+1)'(front_r) + (IW+1)'(count_r - CW'(1)));
              strobe_nxt = 1'b0;
              state_nxt  = S_POP;
            end
          end
          OP_DUMP, OP_REPLACE: begin
            if (is_empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              // first read at the front, the scan then follows one per cycle
              rd_addr    = front_r;
              daddr_nxt  = front_r;
              ptr_nxt    = inc(front_r);
              idx_nxt    = '0;
              strobe_nxt = 1'b0;
              state_nxt  = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        state_nxt  = S_IDLE;
        strobe_nxt = 1'b1;
        last_nxt   = 1'b1;
        data_nxt   = rd_data_r;
        count_nxt  = count_r - CW'(1);
        if (op_r == OP_POP_FRONT) begin
          front_nxt = inc(front_r);
        end
      end
      S_SCAN: begin
        // rd_data_r holds element idx_r, taken from daddr_r
        rd_addr   = ptr_r;
        ptr_nxt   = inc(ptr_r);
        daddr_nxt = ptr_r;
        idx_nxt   = idx_r + IW'(1);
        if (op_r == OP_DUMP) begin
          strobe_nxt = 1'b1;
          data_nxt   = rd_data_r;
          last_nxt   = is_last;
          if (is_last) begin
            state_nxt = S_IDLE;
          end
        end else if (rd_data_r == value_r) begin
          we         = 1'b1;
          wa         = daddr_r;
          wd         = new_value_r;
          strobe_nxt = 1'b1;
          last_nxt   = 1'b1;
          state_nxt  = S_IDLE;
        end else if (is_last) begin
          strobe_nxt = 1'b1;
          last_nxt   = 1'b1;
          status_nxt = ST_NOTFOUND;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // one item at a time: a write always lands before the next item's reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      front_r    <= '0;
      count_r    <= '0;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      front_r    <= front_nxt;
      count_r    <= count_nxt;
      out_strobe <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r        <= op_t'(in_op);
      value_r     <= in_value;
      new_value_r <= in_new_value;
    end
    ptr_r      <= ptr_nxt;
    daddr_r    <= daddr_nxt;
    idx_r      <= idx_nxt;
    out_status <= status_nxt;
    out_data   <= data_nxt;
    out_last   <= last_nxt;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count above depth");

  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= IW'(DEPTH - 1))
    else $error("front index out of range");

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without an item in work");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_last == !busy))
    else $error("last flag and busy disagree");

  a_scan_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_POP) |-> (count_r != '0))
    else $error("memory walk on an empty queue");
`endif

endmodule : double_ended_queue_with_replace_core

`default_nettype wire
